### src/clock_synth_frequency_programmer_core_defines.svh
// ----------------------------------------------------------------------------
// clock synth frequency programmer - assertion macros
// shared concurrent assertion forms for the programmer core
// ----------------------------------------------------------------------------
`ifndef CLOCK_SYNTH_FREQUENCY_PROGRAMMER_CORE_DEFINES_SVH
`define CLOCK_SYNTH_FREQUENCY_PROGRAMMER_CORE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define CFSP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CFSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/cfsp_pkg.sv
// ----------------------------------------------------------------------------
// cfsp_pkg
// types, constants and byte packing shared by the frequency programmer
// ----------------------------------------------------------------------------
package cfsp_pkg;

    localparam logic [29:0] VCO_MAX_HZ     = 30'd900000000;
    localparam logic [19:0] FRAC_DENOM     = 20'd1048575;
    localparam logic [19:0] DIV_DENOM      = 20'd1;
    localparam logic [27:0] F_MIN_HZ       = 28'd500000;
    localparam logic [27:0] F_MAX_HZ       = 28'd225000000;
    localparam logic [7:0]  PLL_RESET_BYTE = 8'hA0;
    localparam logic [17:0] P1_OFFSET      = 18'd512;
    localparam int          QUEUE_DEPTH    = 2;
    localparam int          QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int          QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    // step counts of the shared divider
    localparam logic [4:0]  STEPS_DIVIDER  = 5'd11;
    localparam logic [4:0]  STEPS_MULT     = 5'd30;
    localparam logic [4:0]  STEPS_NUM      = 5'd20;

    // write slots of one run
    localparam logic [4:0]  SLOT_PLL_LAST  = 5'd7;
    localparam logic [4:0]  SLOT_RESET     = 5'd16;
    localparam logic [4:0]  SLOT_CLK_CTL   = 5'd17;
    localparam logic [1:0]  CH_PLL_ONLY    = 2'd3;

    // register reset values
    localparam logic [25:0] RST_CRYSTAL_HZ   = 26'd25000000;
    localparam logic [7:0]  RST_PLL_BASE     = 8'd26;
    localparam logic [7:0]  RST_DIV_BASE     = 8'd42;
    localparam logic [7:0]  RST_PLL_RST_ADDR = 8'd177;
    localparam logic [7:0]  RST_CLK_CTL_BASE = 8'd16;
    localparam logic [7:0]  RST_CLK_CTL_VAL  = 8'd79;
    localparam logic [6:0]  RST_R_DIV_BITS   = 7'd0;

    localparam int APB_ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_CRYSTAL_HZ   = 3'd0,
        REG_PLL_BASE     = 3'd1,
        REG_DIV_BASE     = 3'd2,
        REG_PLL_RST_ADDR = 3'd3,
        REG_CLK_CTL_BASE = 3'd4,
        REG_CLK_CTL_VAL  = 3'd5,
        REG_R_DIV_BITS   = 3'd6
    } t_reg_idx;

    typedef enum logic [3:0] {
        CS_IDLE,
        CS_DIV_DIVIDER,
        CS_MUL_PLL,
        CS_DIV_MULT,
        CS_PREP_NUM,
        CS_DIV_NUM,
        CS_FINISH,
        CS_DONE
    } t_calc_state;

    typedef struct packed {
        logic [25:0] crystal_hz;
        logic [7:0]  pll_base_address;
        logic [7:0]  divider_base_address;
        logic [7:0]  pll_reset_address;
        logic [7:0]  clock_control_base;
        logic [7:0]  clock_control_value;
        logic [6:0]  r_divider_bits;
    } t_cfg;

    typedef struct packed {
        logic [27:0] frequency_hz;
        logic [1:0]  output_channel;
        logic        range_error;
        logic        pll_only;
    } t_item;

    typedef struct packed {
        logic [17:0] pll_p1;
        logic [19:0] pll_p2;
        logic [17:0] div_p1;
        logic [1:0]  output_channel;
        logic        range_error;
        logic        pll_only;
    } t_plan;

    // one parameter byte of an eight byte block
    function automatic logic [7:0] pack_byte(input logic [2:0]  idx,
                                             input logic [17:0] p1,
                                             input logic [19:0] p2,
                                             input logic [19:0] p3,
                                             input logic [6:0]  extra2);
        logic [7:0] b;
        case (idx)
            3'd0:    b = p3[15:8];
            3'd1:    b = p3[7:0];
            3'd2:    b = {1'b0, extra2} | {6'd0, p1[17:16]};
            3'd3:    b = p1[15:8];
            3'd4:    b = p1[7:0];
            3'd5:    b = {p3[19:16], p2[19:16]};
            3'd6:    b = p2[15:8];
            default: b = p2[7:0];
        endcase
        return b;
    endfunction

endpackage

### src/cfsp_if.sv
// ----------------------------------------------------------------------------
// cfsp channel interfaces
// valid/ready channels for request items and register write beats
// ----------------------------------------------------------------------------
interface cfsp_in_if;
    logic        valid;
    logic        ready;
    logic [27:0] frequency_hz;
    logic [1:0]  output_channel;

    modport source (output valid, output frequency_hz, output output_channel, input ready);
    modport sink   (input valid, input frequency_hz, input output_channel, output ready);
endinterface

interface cfsp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] wr_addr;
    logic [7:0] wr_data;
    logic       last_write;
    logic       range_error;

    modport source (output valid, output wr_addr, output wr_data,
                    output last_write, output range_error, input ready);
    modport sink   (input valid, input wr_addr, input wr_data,
                    input last_write, input range_error, output ready);
endinterface

### src/cfsp_front.sv
// ----------------------------------------------------------------------------
// cfsp_front
// takes request beats, range checks them and tags pll-only requests
// ----------------------------------------------------------------------------
module cfsp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    cfsp_in_if.sink         i_in_ch,
    output logic            o_valid,
    output cfsp_pkg::t_item o_item,
    input  logic            i_ready
);

    logic            r_valid;
    cfsp_pkg::t_item r_item;
    cfsp_pkg::t_item n_item;
    logic            w_take;

    assign i_in_ch.ready = !r_valid || i_ready;
    assign w_take        = i_in_ch.valid && i_in_ch.ready;

    always_comb begin
        n_item.frequency_hz   = i_in_ch.frequency_hz;
        n_item.output_channel = i_in_ch.output_channel;
        n_item.range_error    = (i_in_ch.frequency_hz < cfsp_pkg::F_MIN_HZ) ||
                                (i_in_ch.frequency_hz > cfsp_pkg::F_MAX_HZ);
        n_item.pll_only       = (i_in_ch.output_channel == cfsp_pkg::CH_PLL_ONLY);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### src/cfsp_queue.sv
// ----------------------------------------------------------------------------
// cfsp_queue
// short fifo of classified requests between front and calculator
// ----------------------------------------------------------------------------
module cfsp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  cfsp_pkg::t_item i_item,
    output logic            o_ready,
    output logic            o_valid,
    output cfsp_pkg::t_item o_item,
    input  logic            i_ready
);

    cfsp_pkg::t_item                  r_mem [cfsp_pkg::QUEUE_DEPTH];
    logic [cfsp_pkg::QPTR_W-1:0]      r_wr_ptr;
    logic [cfsp_pkg::QPTR_W-1:0]      r_rd_ptr;
    logic [cfsp_pkg::QCNT_W-1:0]      r_count;
    logic                             w_push;
    logic                             w_pop;

    assign o_ready = (r_count != cfsp_pkg::QCNT_W'(cfsp_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == cfsp_pkg::QPTR_W'(cfsp_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == cfsp_pkg::QPTR_W'(cfsp_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

### src/cfsp_calc.sv
// ----------------------------------------------------------------------------
// cfsp_calc
// works out the pll and divider parameter words with one shared
// restoring divider that retires one quotient bit per cycle
// ----------------------------------------------------------------------------
module cfsp_calc (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cfsp_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    input  cfsp_pkg::t_item i_item,
    output logic            o_ready,
    output logic            o_valid,
    output cfsp_pkg::t_plan o_plan,
    input  logic            i_ready
);

    cfsp_pkg::t_calc_state r_state;
    cfsp_pkg::t_calc_state n_state;

    cfsp_pkg::t_item r_item;
    cfsp_pkg::t_plan r_plan;
    logic [28:0]     r_rem;
    logic [45:0]     r_dvd;
    logic [19:0]     r_quo;
    logic [4:0]      r_cnt;
    logic [10:0]     r_divider;
    logic [7:0]      r_mult;
    logic [19:0]     r_num;

    logic [27:0]     w_divisor;
    logic [28:0]     w_trial;
    logic [29:0]     w_diff;
    logic            w_ge;
    logic [28:0]     n_rem;
    logic [19:0]     n_quo;
    logic            w_last_step;
    logic            w_take;
    logic [38:0]     w_prod;
    logic [45:0]     w_scaled;
    logic [20:0]     w_fp_low;
    logic            w_fp_up;
    logic [6:0]      w_fp;

    assign w_take      = i_valid && o_ready;
    assign w_last_step = (r_cnt == 5'd1);

    always_comb begin
        case (r_state)
            cfsp_pkg::CS_DIV_DIVIDER: w_divisor = r_item.frequency_hz;
            default:                  w_divisor = {2'd0, i_cfg.crystal_hz};
        endcase
    end

    // one restoring step
    assign w_trial = {r_rem[27:0], r_dvd[45]};
    assign w_diff  = {1'b0, w_trial} - {2'd0, w_divisor};
    assign w_ge    = !w_diff[29];
    assign n_rem   = w_ge ? w_diff[28:0] : w_trial;
    assign n_quo   = {r_quo[18:0], w_ge};

    assign w_prod   = r_divider * r_item.frequency_hz;
    // rem * (2^20 - 1)
    assign w_scaled = {r_rem[25:0], 20'd0} - {20'd0, r_rem[25:0]};

    // fp = 128*num / (2^20-1): estimate num >> 13, then at most one step up
    assign w_fp_low = {1'b0, r_num[12:0], 7'd0} + {14'd0, r_num[19:13]};
    assign w_fp_up  = (w_fp_low >= {1'b0, cfsp_pkg::FRAC_DENOM});
    assign w_fp     = r_num[19:13] + {6'd0, w_fp_up};

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            cfsp_pkg::CS_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = i_item.range_error ? cfsp_pkg::CS_FINISH :
                                                   cfsp_pkg::CS_DIV_DIVIDER;
                end
            end
            cfsp_pkg::CS_DIV_DIVIDER: begin
                if (w_last_step) begin
                    n_state = cfsp_pkg::CS_MUL_PLL;
                end
            end
            cfsp_pkg::CS_MUL_PLL: begin
                n_state = (i_cfg.crystal_hz == '0) ? cfsp_pkg::CS_FINISH :
                                                     cfsp_pkg::CS_DIV_MULT;
            end
            cfsp_pkg::CS_DIV_MULT: begin
                if (w_last_step) begin
                    n_state = cfsp_pkg::CS_PREP_NUM;
                end
            end
            cfsp_pkg::CS_PREP_NUM: n_state = cfsp_pkg::CS_DIV_NUM;
            cfsp_pkg::CS_DIV_NUM: begin
                if (w_last_step) begin
                    n_state = cfsp_pkg::CS_FINISH;
                end
            end
            cfsp_pkg::CS_FINISH: n_state = cfsp_pkg::CS_DONE;
            cfsp_pkg::CS_DONE: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_state = cfsp_pkg::CS_IDLE;
                end
            end
            default: n_state = cfsp_pkg::CS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cfsp_pkg::CS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            cfsp_pkg::CS_IDLE: begin
                if (w_take) begin
                    r_item <= i_item;
                    // 900e6 >> 11 is below the smallest legal frequency
                    r_rem  <= {10'd0, cfsp_pkg::VCO_MAX_HZ[29:11]};
                    r_dvd  <= {cfsp_pkg::VCO_MAX_HZ[10:0], 35'd0};
                    r_cnt  <= cfsp_pkg::STEPS_DIVIDER;
                end
            end
            cfsp_pkg::CS_DIV_DIVIDER, cfsp_pkg::CS_DIV_MULT,
            cfsp_pkg::CS_DIV_NUM: begin
                r_rem <= n_rem;
                r_dvd <= {r_dvd[44:0], 1'b0};
                r_quo <= n_quo;
                r_cnt <= r_cnt - 1'b1;
                if (w_last_step && r_state == cfsp_pkg::CS_DIV_DIVIDER) begin
                    r_divider <= {n_quo[10:1], 1'b0};
                end
                if (w_last_step && r_state == cfsp_pkg::CS_DIV_MULT) begin
                    r_mult <= n_quo[7:0];
                end
                if (w_last_step && r_state == cfsp_pkg::CS_DIV_NUM) begin
                    r_num <= n_quo[19:0];
                end
            end
            cfsp_pkg::CS_MUL_PLL: begin
                r_mult <= '0;
                r_num  <= '0;
                r_rem  <= '0;
                r_dvd  <= {w_prod[29:0], 16'd0};
                r_cnt  <= cfsp_pkg::STEPS_MULT;
            end
            cfsp_pkg::CS_PREP_NUM: begin
                r_rem <= {3'd0, w_scaled[45:20]};
                r_dvd <= {w_scaled[19:0], 26'd0};
                r_cnt <= cfsp_pkg::STEPS_NUM;
            end
            cfsp_pkg::CS_FINISH: begin
                r_plan.pll_p1 <= {3'd0, r_mult, 7'd0} + {11'd0, w_fp} - cfsp_pkg::P1_OFFSET;
                // 128*num - (2^20-1)*fp, modulo 2^20
                r_plan.pll_p2 <= {r_num[12:0], 7'd0} + {13'd0, w_fp};
                r_plan.div_p1 <= {r_divider, 7'd0} - cfsp_pkg::P1_OFFSET;
                r_plan.output_channel <= r_item.output_channel;
                r_plan.range_error    <= r_item.range_error;
                r_plan.pll_only       <= r_item.pll_only;
            end
            default: begin
            end
        endcase
    end

    assign o_plan = r_plan;

endmodule

### src/cfsp_emit.sv
// ----------------------------------------------------------------------------
// cfsp_emit
// sends the register writes of a finished plan, one beat a cycle when ready
// ----------------------------------------------------------------------------
`include "clock_synth_frequency_programmer_core_defines.svh"

module cfsp_emit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cfsp_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    input  cfsp_pkg::t_plan i_plan,
    output logic            o_ready,
    cfsp_out_if.source      o_out_ch
);

    logic            r_busy;
    cfsp_pkg::t_plan r_plan;
    logic [4:0]      r_cnt;
    logic            r_ovalid;
    logic [7:0]      r_addr;
    logic [7:0]      r_data;
    logic            r_last;
    logic            r_err;

    logic [7:0]      n_addr;
    logic [7:0]      n_data;
    logic            n_last;
    logic            n_err;
    logic            w_load;
    logic            w_take;

    assign o_ready = !r_busy;
    assign w_take  = i_valid && !r_busy;
    assign w_load  = r_busy && (!r_ovalid || o_out_ch.ready);

    always_comb begin
        n_err  = 1'b0;
        n_last = 1'b0;
        if (r_plan.range_error) begin
            n_addr = '0;
            n_data = '0;
            n_last = 1'b1;
            n_err  = 1'b1;
        end else begin
            case (r_cnt) inside
                [5'd0:5'd7]: begin
                    n_addr = i_cfg.pll_base_address + {5'd0, r_cnt[2:0]};
                    n_data = cfsp_pkg::pack_byte(r_cnt[2:0], r_plan.pll_p1, r_plan.pll_p2,
                                                 cfsp_pkg::FRAC_DENOM, 7'd0);
                    n_last = r_plan.pll_only && (r_cnt == cfsp_pkg::SLOT_PLL_LAST);
                end
                [5'd8:5'd15]: begin
                    n_addr = i_cfg.divider_base_address +
                             {3'd0, r_plan.output_channel, r_cnt[2:0]};
                    n_data = cfsp_pkg::pack_byte(r_cnt[2:0], r_plan.div_p1, 20'd0,
                                                 cfsp_pkg::DIV_DENOM, i_cfg.r_divider_bits);
                end
                cfsp_pkg::SLOT_RESET: begin
                    n_addr = i_cfg.pll_reset_address;
                    n_data = cfsp_pkg::PLL_RESET_BYTE;
                end
                default: begin
                    n_addr = i_cfg.clock_control_base + {6'd0, r_plan.output_channel};
                    n_data = i_cfg.clock_control_value;
                    n_last = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (w_take) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (w_load) begin
                if (n_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_plan <= i_plan;
        end
        if (w_load) begin
            r_addr <= n_addr;
            r_data <= n_data;
            r_last <= n_last;
            r_err  <= n_err;
        end
    end

    assign o_out_ch.valid       = r_ovalid;
    assign o_out_ch.wr_addr     = r_addr;
    assign o_out_ch.wr_data     = r_data;
    assign o_out_ch.last_write  = r_last;
    assign o_out_ch.range_error = r_err;

    `CFSP_ASSERT_SAME(a_err_is_last, i_clk, i_rst_n, r_ovalid && r_err, r_last,
        "range error beat without last_write")
    `CFSP_ASSERT_SAME(a_slot_bound, i_clk, i_rst_n, r_busy, r_cnt <= cfsp_pkg::SLOT_CLK_CTL,
        "write slot past end of run")
    `CFSP_ASSERT_SAME(a_pll_only_bound, i_clk, i_rst_n, r_busy && r_plan.pll_only,
        r_cnt <= cfsp_pkg::SLOT_PLL_LAST, "pll-only run past its eighth write")
    `CFSP_ASSERT_NEXT(a_last_frees, i_clk, i_rst_n, w_load && n_last, !r_busy && r_ovalid,
        "emitter still busy after last write")

endmodule

### src/clock_synth_frequency_programmer_core.sv
// ----------------------------------------------------------------------------
// clock_synth_frequency_programmer_core
// turns a target frequency and output channel into the register writes
// that program a fractional pll and an integer output divider
// ----------------------------------------------------------------------------
// channel    dir  modport  beat
// i_in_ch    in   sink     frequency_hz, output_channel
// o_out_ch   out  source   wr_addr, wr_data, last_write, range_error
// apb        in   slave    crystal, addresses, control byte, r divider bits
//
// a legal request holds the calculator for 11 + 30 + 20 steps of the shared
//   bit-per-cycle divider, two setup states, finish, hand-off and idle
// a zero crystal skips the last two divisions; out of range goes to finish
// the emitter then sends 18 beats (8 for pll only, 1 for out of range) from
//   its registered plan, while the calculator works on the next request
// synchronous active-low reset clears control state and loads register defaults
// either side may stall at any time; a 2-deep queue sits behind the front
// ----------------------------------------------------------------------------
module clock_synth_frequency_programmer_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    cfsp_in_if.sink                         i_in_ch,
    cfsp_out_if.source                      o_out_ch,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cfsp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    cfsp_pkg::t_cfg  r_cfg;
    logic [2:0]      w_idx;
    logic            w_wr;

    logic            w_f_valid;
    cfsp_pkg::t_item w_f_item;
    logic            w_f_ready;
    logic            w_q_valid;
    cfsp_pkg::t_item w_q_item;
    logic            w_q_ready;
    logic            w_c_valid;
    cfsp_pkg::t_plan w_c_plan;
    logic            w_c_ready;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.crystal_hz           <= cfsp_pkg::RST_CRYSTAL_HZ;
            r_cfg.pll_base_address     <= cfsp_pkg::RST_PLL_BASE;
            r_cfg.divider_base_address <= cfsp_pkg::RST_DIV_BASE;
            r_cfg.pll_reset_address    <= cfsp_pkg::RST_PLL_RST_ADDR;
            r_cfg.clock_control_base   <= cfsp_pkg::RST_CLK_CTL_BASE;
            r_cfg.clock_control_value  <= cfsp_pkg::RST_CLK_CTL_VAL;
            r_cfg.r_divider_bits       <= cfsp_pkg::RST_R_DIV_BITS;
        end else if (w_wr) begin
            case (w_idx)
                cfsp_pkg::REG_CRYSTAL_HZ:   r_cfg.crystal_hz           <= pwdata[25:0];
                cfsp_pkg::REG_PLL_BASE:     r_cfg.pll_base_address     <= pwdata[7:0];
                cfsp_pkg::REG_DIV_BASE:     r_cfg.divider_base_address <= pwdata[7:0];
                cfsp_pkg::REG_PLL_RST_ADDR: r_cfg.pll_reset_address    <= pwdata[7:0];
                cfsp_pkg::REG_CLK_CTL_BASE: r_cfg.clock_control_base   <= pwdata[7:0];
                cfsp_pkg::REG_CLK_CTL_VAL:  r_cfg.clock_control_value  <= pwdata[7:0];
                cfsp_pkg::REG_R_DIV_BITS:   r_cfg.r_divider_bits       <= pwdata[6:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            cfsp_pkg::REG_CRYSTAL_HZ:   prdata = {6'd0, r_cfg.crystal_hz};
            cfsp_pkg::REG_PLL_BASE:     prdata = {24'd0, r_cfg.pll_base_address};
            cfsp_pkg::REG_DIV_BASE:     prdata = {24'd0, r_cfg.divider_base_address};
            cfsp_pkg::REG_PLL_RST_ADDR: prdata = {24'd0, r_cfg.pll_reset_address};
            cfsp_pkg::REG_CLK_CTL_BASE: prdata = {24'd0, r_cfg.clock_control_base};
            cfsp_pkg::REG_CLK_CTL_VAL:  prdata = {24'd0, r_cfg.clock_control_value};
            cfsp_pkg::REG_R_DIV_BITS:   prdata = {25'd0, r_cfg.r_divider_bits};
            default:                    prdata = '0;
        endcase
    end

    cfsp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in_ch (i_in_ch),
        .o_valid (w_f_valid),
        .o_item  (w_f_item),
        .i_ready (w_f_ready)
    );

    cfsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .i_item  (w_f_item),
        .o_ready (w_f_ready),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_ready (w_q_ready)
    );

    cfsp_calc u_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_q_valid),
        .i_item  (w_q_item),
        .o_ready (w_q_ready),
        .o_valid (w_c_valid),
        .o_plan  (w_c_plan),
        .i_ready (w_c_ready)
    );

    cfsp_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (w_c_valid),
        .i_plan   (w_c_plan),
        .o_ready  (w_c_ready),
        .o_out_ch (o_out_ch)
    );

endmodule
